/* src/sida_pkg.sv */
// Shared types and constants for the signed integer to decimal text converter.
`default_nettype none

package sida_pkg;

    localparam int ValueWidth = 32;
    localparam int NumDigits  = 10;
    localparam int BcdWidth   = 4 * NumDigits;
    localparam int CountWidth = $clog2(ValueWidth);
    localparam int PosWidth   = $clog2(NumDigits);

    localparam logic [7:0] CharMinus = 8'd45;
    localparam logic [7:0] CharZero  = 8'd48;
    localparam logic [7:0] CharNine  = 8'd57;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SETUP,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic setup;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic negative;
        logic pos_zero;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* src/sida_ctrl.sv */
// Sequencing state machine: load, binary-to-BCD shift, then character emission.
`default_nettype none

module sida_ctrl
    import sida_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    value_valid,
    output logic         value_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        value_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                value_stall = 1'b0;
                if (value_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cmd.shift = 1'b1;
                if (status.conv_done)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.negative ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.pos_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/sida_datapath.sv */
// Magnitude, shift-add-3 BCD converter, digit pointer and output register.
`default_nettype none

module sida_datapath
    import sida_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic signed [31:0]     value,
    input  wire cmd_t                   cmd,
    output status_t                     status,
    output logic [7:0]                  character,
    output logic                        last,
    output logic                        result_valid,
    input  wire logic                   result_stall
);

    logic                  neg_reg;
    logic [ValueWidth-1:0] bin_reg;
    logic [ValueWidth-1:0] bin_next;
    logic [BcdWidth-1:0]   bcd_reg;
    logic [BcdWidth-1:0]   bcd_next;
    logic [BcdWidth-1:0]   bcd_adj;
    logic [CountWidth-1:0] cnt_reg;
    logic [PosWidth-1:0]   pos_reg;
    logic [PosWidth-1:0]   lead;
    logic [3:0]            digit_sel;
    logic [ValueWidth-1:0] raw;
    logic [ValueWidth-1:0] mag;
    logic [7:0]            char_reg;
    logic                  last_reg;
    logic                  valid_reg;

    assign raw = value;
    assign mag = raw[ValueWidth-1] ? (ValueWidth'(0) - raw) : raw;

    // add 3 to every digit of 5 or more, then shift in the next binary bit
    always_comb
    begin
        for (int i = 0; i < NumDigits; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    assign bcd_next = {bcd_adj[BcdWidth-2:0], bin_reg[ValueWidth-1]};
    assign bin_next = {bin_reg[ValueWidth-2:0], 1'b0};

    // highest nonzero digit; zero value keeps the ones digit
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < NumDigits; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
            begin
                lead = PosWidth'(i);
            end
        end
    end

    assign digit_sel = bcd_reg[{pos_reg, 2'b00} +: 4];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= raw[ValueWidth-1];
            bin_reg <= mag;
            bcd_reg <= '0;
        end
        else if (cmd.shift)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end

        if (cmd.setup)
        begin
            pos_reg <= lead;
        end
        else if (cmd.emit_digit)
        begin
            pos_reg <= pos_reg - PosWidth'(1);
        end

        if (cmd.emit_sign)
        begin
            char_reg <= CharMinus;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= CharZero + {4'b0000, digit_sel};
            last_reg <= (pos_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.shift)
            begin
                cnt_reg <= cnt_reg + CountWidth'(1);
            end

            if (cmd.emit_sign || cmd.emit_digit)
            begin
                valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign status.conv_done = (cnt_reg == CountWidth'(ValueWidth - 1));
    assign status.negative  = neg_reg;
    assign status.pos_zero  = (pos_reg == '0);
    assign status.out_free  = !valid_reg || !result_stall;

    assign character    = char_reg;
    assign last         = last_reg;
    assign result_valid = valid_reg;

endmodule

`default_nettype wire

/* src/signed_int_to_decimal_ascii.sv */
// Top level: signed 32-bit integer to decimal ASCII character stream.
// Each accepted item is converted, then sent out as N characters, N = 1..11.
// The 32-step shift-add-3 BCD loop does the conversion; emission is 1 char/cycle
// while the output is not stalled; no new item is taken before the last character.
// Output register lets the last character wait while the next item is taken.
// Reset (rst_n, async, active low) idles the controller and empties the output.
`default_nettype none

module signed_int_to_decimal_ascii
    import sida_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input channel: one integer per item
    input  wire logic               value_valid,
    output logic                    value_stall,
    input  wire logic signed [31:0] value,
    // output channel: one character per item
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [7:0]              character,
    output logic                    last
);

    cmd_t    cmd;
    status_t status;

    // Controller: idle -> shift loop -> pick leading digit -> sign (if negative) -> digits.
    sida_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .status      (status),
        .cmd         (cmd)
    );

    // Datapath: magnitude (exact for the most negative value), BCD register,
    // digit pointer walking down from the leading nonzero digit, output stage.
    sida_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .cmd          (cmd),
        .status       (status),
        .character    (character),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

`default_nettype wire

/* src/sida_checker.sv */
// Port-level assertions for the converter, bound to the top level.
`default_nettype none

module sida_checker
    import sida_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               value_valid,
    input wire logic               value_stall,
    input wire logic signed [31:0] value,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire logic [7:0]         character,
    input wire logic               last
);

    // a stalled input item keeps its value
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && value_stall |=> value_valid && $stable(value))
        else $error("input item changed while stalled");

    // a held character keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(character) && $stable(last))
        else $error("output item changed while stalled");

    // after taking an item the block is busy converting
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && !value_stall |=> value_stall)
        else $error("input taken again right after an accept");

    // only sign or decimal digits appear
    a_chars: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (character == CharMinus) || ((character >= CharZero) && (character <= CharNine)))
        else $error("illegal character emitted");

    // the sign never ends a run
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (character == CharMinus) |-> !last)
        else $error("sign marked as last character");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (.*);

`default_nettype wire

/* tb/tb_signed_int_to_decimal_ascii.sv */
// Testbench for signed_int_to_decimal_ascii: random and directed integers, checked per character.
`default_nettype none

module tb_signed_int_to_decimal_ascii;

    import sida_pkg::*;

    // One character of expected decimal text.
    typedef struct packed {
        logic [7:0] code;
        logic       is_last;
    } text_char_t;

    localparam int RandomItems = 80;
    localparam int TailItems   = 20;     // final items run with no idling on either side
    localparam int HoldStart   = 30;     // items sent before the long receiver hold-off
    localparam int HoldCycles  = 300;    // long enough to back the block up into its input
    localparam int DrainCycles = 60;     // covers the block's conversion plus up to 11 characters
    localparam int CycleLimit  = 200000;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               value_valid  = 1'b0;
    logic               value_stall;
    logic signed [31:0] value        = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [7:0]         character;
    logic               last;

    logic signed [31:0] pending_values[$];   // integers still to be offered
    text_char_t         expected_chars[$];   // characters predicted but not yet seen
    text_char_t         want;

    int error_count = 0;
    int items_sent  = 0;
    int total_items = 0;
    int send_gap    = 0;
    int stall_left  = 0;
    int free_left   = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    bit stall_now;
    int cycle_count = 0;

    signed_int_to_decimal_ascii u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .value_valid  (value_valid),
        .value_stall  (value_stall),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .character    (character),
        .last         (last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction: magnitude is taken as an unsigned 32-bit value, so the
    // most negative integer comes out exactly. Digits are peeled off
    // least significant first and replayed in reverse.
    // ------------------------------------------------------------------
    task automatic predict_text(input logic signed [31:0] v);
        logic [31:0] mag;
        logic [3:0]  digits[10];
        int          nd;
        text_char_t  c;
        mag = v;
        nd  = 0;
        if (v[31])
            mag = 32'd0 - mag;
        do
        begin
            digits[nd] = 4'(mag % 32'd10);
            nd++;
            mag = mag / 32'd10;
        end
        while (mag != 0 && nd < 10);
        if (v[31])
        begin
            c.code    = CharMinus;
            c.is_last = 1'b0;
            expected_chars.push_back(c);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            c.code    = CharZero + 8'(digits[i]);
            c.is_last = (i == 0);
            expected_chars.push_back(c);
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < 40)
            $display("[%0d] mismatch: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic bit quiet_tail();
        return items_sent + TailItems >= total_items;
    endfunction

    // Mostly values of a chosen digit count so every text length shows up
    // about equally; the rest are raw 32-bit patterns.
    function automatic logic signed [31:0] random_value();
        longint      lo;
        longint      hi;
        longint      pick;
        int          ndig;
        logic [31:0] r;
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        ndig = $urandom_range(1, 10);
        lo   = 1;
        for (int i = 1; i < ndig; i++)
            lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1)
            lo = 0;
        if (hi > 64'sd2147483647)
            hi = 64'sd2147483647;
        pick = lo + (longint'({32'd0, $urandom()}) % (hi - lo + 1));
        r    = pick[31:0];
        if ($urandom_range(0, 1))
            r = 32'd0 - r;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers queued integers, holds a stalled item steady, and
    // inserts idle bursts between items except in the tail.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (value_valid && !value_stall)
            begin
                predict_text(value);
                items_sent++;
            end
            if (!value_valid || !value_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    value_valid <= 1'b0;
                end
                else if (pending_values.size() != 0)
                begin
                    value       <= pending_values.pop_front();
                    value_valid <= 1'b1;
                    if (!quiet_tail() && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 14);
                end
                else
                begin
                    value_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts and free stretches, plus one long
    // hold-off so the output fills and the block stalls its input.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            stall_now = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
                stall_now = 1'b1;
            end
            else if (!hold_done && items_sent >= HoldStart)
            begin
                hold_done = 1'b1;
                hold_left = HoldCycles - 1;
                stall_now = 1'b1;
            end
            else if (quiet_tail())
                stall_now = 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                stall_now = 1'b1;
            end
            else if (free_left > 0)
                free_left--;
            else if ($urandom_range(0, 1))
            begin
                stall_left = $urandom_range(1, 14) - 1;
                stall_now  = 1'b1;
            end
            else
                free_left = $urandom_range(1, 40);
            result_stall <= stall_now;
        end
    end

    // Checker: every accepted character against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_chars.size() == 0)
                report_mismatch($sformatf("unexpected character 0x%02h last=%b",
                                          character, last));
            else
            begin
                want = expected_chars.pop_front();
                if (character !== want.code)
                    report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                              character, want.code));
                if (last !== want.is_last)
                    report_mismatch($sformatf("last %b, expected %b on character 0x%02h",
                                              last, want.is_last, want.code));
            end
        end
    end

    // Watchdog.
    initial
    begin
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** signed_int_to_decimal_ascii: FAILED **");
        $finish;
    end

    initial
    begin
        // Directed: zero, single digits, digit-count boundaries, both
        // extremes (most negative spells an eleven-character run), and
        // alternating bit patterns so every input bit toggles.
        pending_values.push_back(32'sd0);
        pending_values.push_back(32'sd1);
        pending_values.push_back(-32'sd1);
        pending_values.push_back(32'sd9);
        pending_values.push_back(32'sd10);
        pending_values.push_back(-32'sd10);
        pending_values.push_back(32'sd99);
        pending_values.push_back(32'sd100);
        pending_values.push_back(-32'sd999);
        pending_values.push_back(32'sd1000000000);
        pending_values.push_back(32'sd999999999);
        pending_values.push_back(-32'sd999999999);
        pending_values.push_back(-32'sd1000000000);
        pending_values.push_back(32'sd2147483647);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h8000_0001);
        pending_values.push_back(32'h5555_5555);
        pending_values.push_back(32'hAAAA_AAAA);
        pending_values.push_back(32'sd1234567890);
        pending_values.push_back(32'sd1000000);
        pending_values.push_back(32'sd0);
        for (int i = 0; i < RandomItems; i++)
            pending_values.push_back(random_value());
        total_items = pending_values.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // All items accepted and every predicted character seen.
        while (pending_values.size() != 0 || value_valid || expected_chars.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (error_count == 0)
            $display("** signed_int_to_decimal_ascii: PASSED **");
        else
            $display("** signed_int_to_decimal_ascii: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

/* signed_int_to_decimal_ascii.f */
src/sida_pkg.sv
src/sida_ctrl.sv
src/sida_datapath.sv
src/signed_int_to_decimal_ascii.sv
src/sida_checker.sv
tb/tb_signed_int_to_decimal_ascii.sv
